// ----- rtl/cqks_pkg.sv -----
// shared constants and codes for the circular queue with key search
`timescale 1ns / 1ps

package cqks_pkg;

   localparam int DEPTH_DEF        = 128;
   localparam int KEY_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int REQ_TYPE_W = 2;
   localparam int STATUS_W   = 2;
   localparam int AHEAD_W    = 7;
   localparam int OCC_W      = 8;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FRONT   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH  = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

// ----- rtl/circular_queue_with_key_search_unit.sv -----
// circular queue of key and payload entries with a linear key search
//
// requests arrive on the req_ channel (valid/ready) and each gives exactly one
// result on the rsp_ channel (valid/ready); results come out in request order.
// enqueue and dequeue answer in the cycle after the request transfer.
// read front reads the store at the head, then registers the result.
// search reads the store one entry a cycle from the head through the single key
// comparator and answers on the first match, or with not found after the last
// entry; an empty queue answers not found without a search.
// one request is worked on at a time; req_ready is high only when no request
// is in progress and the result register is free or being emptied this cycle.
// a stalled receiver holds the result register and so holds off new requests.
// reset empties the queue (head, tail and count to zero); stored entries are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps

module circular_queue_with_key_search_unit #(
   parameter int DEPTH        = cqks_pkg::DEPTH_DEF,
   parameter int KEY_BITS     = cqks_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = cqks_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cqks_pkg::REQ_TYPE_W-1:0]  req_type,
   input  logic [KEY_BITS-1:0]              req_entry_key,
   input  logic [PAYLOAD_BITS-1:0]          req_entry_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cqks_pkg::STATUS_W-1:0]    rsp_status,
   output logic [KEY_BITS-1:0]              rsp_front_key,
   output logic [PAYLOAD_BITS-1:0]          rsp_front_payload,
   output logic [cqks_pkg::AHEAD_W-1:0]     rsp_ahead_count,
   output logic [cqks_pkg::OCC_W-1:0]       rsp_occupancy
);

   import cqks_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FRONT,
      S_SEARCH
   } state_type;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      nxt = (slot == LAST_SLOT) ? '0 : slot + IDX_W'(1);
      return nxt;
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [IDX_W-1:0]        cmp_ff, cmp_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [KEY_BITS-1:0]     fkey_ff, fkey_in;
   logic [PAYLOAD_BITS-1:0] fpay_ff, fpay_in;
   logic [AHEAD_W-1:0]      ahead_ff, ahead_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;

   logic                    req_fire;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_payload;
   logic                    key_hit;
   logic                    last_entry;

   cqks_store #(
      .DEPTH        (DEPTH),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IDX_W        (IDX_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (tail_ff),
      .wr_key     (req_entry_key),
      .wr_payload (req_entry_payload),
      .rd_addr    (rd_addr),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign rd_addr    = (state_ff == S_SEARCH) ? slot_ff : head_ff;
   assign key_hit    = (rd_key == key_ff);
   assign last_entry = ((CNT_W'(cmp_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      cmp_in       = cmp_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      fkey_in      = fkey_ff;
      fpay_in      = fpay_ff;
      ahead_in     = ahead_ff;
      occ_in       = occ_ff;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = STAT_OK;
               fkey_in   = '0;
               fpay_in   = '0;
               ahead_in  = '0;
               unique case (req_type)
                  REQ_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_slot(tail_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DEQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        head_in  = next_slot(head_ff);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_FRONT: begin
                     if (count_ff == '0) begin
                        status_in    = STAT_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_FRONT;
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in    = STAT_NOT_FOUND;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                        key_in   = req_entry_key;
                        cmp_in   = '0;
                        slot_in  = next_slot(head_ff);
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
               occ_in = OCC_W'(count_in);
            end
         end
         S_FRONT: begin
            fkey_in      = rd_key;
            fpay_in      = rd_payload;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SEARCH: begin
            slot_in = next_slot(slot_ff);
            if (key_hit) begin
               ahead_in     = AHEAD_W'(cmp_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (last_entry) begin
               status_in    = STAT_NOT_FOUND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmp_in = cmp_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff   <= slot_in;
      cmp_ff    <= cmp_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      fkey_ff   <= fkey_in;
      fpay_ff   <= fpay_in;
      ahead_ff  <= ahead_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_front_key     = fkey_ff;
   assign rsp_front_payload = fpay_ff;
   assign rsp_ahead_count   = ahead_ff;
   assign rsp_occupancy     = occ_ff;

endmodule

// ----- rtl/cqks_store.sv -----
// entry store: one write port and one registered read port for key and payload
`timescale 1ns / 1ps

module cqks_store #(
   parameter int DEPTH        = cqks_pkg::DEPTH_DEF,
   parameter int KEY_BITS     = cqks_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = cqks_pkg::PAYLOAD_BITS_DEF,
   parameter int IDX_W        = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [PAYLOAD_BITS-1:0] wr_payload,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [KEY_BITS-1:0]     rd_key,
   output logic [PAYLOAD_BITS-1:0] rd_payload
);

   import cqks_pkg::*;

   logic [KEY_BITS-1:0]     key_mem     [DEPTH];
   logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]     <= wr_key;
         payload_mem[wr_addr] <= wr_payload;
      end
      rd_key     <= key_mem[rd_addr];
      rd_payload <= payload_mem[rd_addr];
   end

endmodule
